// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the timer bank RTL.
// Depends on nothing; each use needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/metb_pkg.sv -----
// Package for the elapsed timer bank: field widths, op codes and the command type.
// Depends on nothing; every other file of the block but assert_macros.svh imports it.
`timescale 1ns / 1ps

package metb_pkg;

    localparam int OP_W        = 2;
    localparam int CH_W        = 4;
    localparam int STAMP_W     = 32;
    localparam int DEF_CHANNELS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CHECK   = 2'd0,
        OP_PENDING = 2'd1,
        OP_RESTART = 2'd2,
        OP_SET     = 2'd3
    } metb_op_t;

    typedef struct packed {
        metb_op_t             op;
        logic [CH_W-1:0]      channel;
        logic [STAMP_W-1:0]   now_ms;
        logic [STAMP_W-1:0]   time_value;
    } metb_cmd_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } metb_stage_ctl_t;

endpackage

// ----- rtl/metb_if.sv -----
// Handshake interfaces for the command and result channels of the timer bank.
// Depends on metb_pkg for the field widths.
`timescale 1ns / 1ps

interface metb_cmd_if
    import metb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CH_W-1:0]    channel;
    logic [STAMP_W-1:0] now_ms;
    logic [STAMP_W-1:0] time_value;

    modport source (output valid, output op, output channel, output now_ms,
                    output time_value, input ready);
    modport sink   (input valid, input op, input channel, input now_ms,
                    input time_value, output ready);
endinterface

interface metb_res_if;
    logic valid;
    logic ready;
    logic elapsed;

    modport source (output valid, output elapsed, input ready);
    modport sink   (input valid, input elapsed, output ready);
endinterface

// ----- rtl/metb_input_stage.sv -----
// Input register of the timer bank: captures one command item per cycle while the result stage does not stall.
// Depends on metb_pkg and metb_cmd_if.
`timescale 1ns / 1ps

module metb_input_stage
    import metb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    metb_cmd_if.sink        cmd,
    input  logic            advance,
    output metb_stage_ctl_t ctl,
    output metb_cmd_t       stage_cmd
);

    logic      valid_reg;
    logic      valid_next;
    metb_cmd_t cmd_reg;
    logic      take;

    assign cmd.ready  = !valid_reg || advance;
    assign take       = cmd.valid && cmd.ready;
    assign valid_next = cmd.ready ? cmd.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op         <= metb_op_t'(cmd.op);
            cmd_reg.channel    <= cmd.channel;
            cmd_reg.now_ms     <= cmd.now_ms;
            cmd_reg.time_value <= cmd.time_value;
        end
    end

    assign ctl.valid   = valid_reg;
    assign ctl.advance = advance;
    assign stage_cmd   = cmd_reg;

endmodule

// ----- rtl/metb_timer_core.sv -----
// Channel state of the timer bank and the combinational evaluation of one command.
// Depends on metb_pkg.
`timescale 1ns / 1ps

module metb_timer_core
    import metb_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  metb_stage_ctl_t ctl,
    input  metb_cmd_t       stage_cmd,
    output logic            hit
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = ((CH_W > IDX_W) ? CH_W : IDX_W) + 1;

    logic [STAMP_W-1:0]  stamps_reg [CHANNELS];
    logic [CHANNELS-1:0] pend_reg;

    logic [CMP_W-1:0]   ch_ext;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               fire;
    logic               pending;
    logic [STAMP_W-1:0] stamp_cur;
    logic [STAMP_W-1:0] end_stamp;
    logic               reached;
    logic               stamp_we;
    logic [STAMP_W-1:0] stamp_wdata;
    logic               pend_we;
    logic               pend_wdata;

    assign ch_ext   = CMP_W'(stage_cmd.channel);
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = ch_ext < CMP_W'(CHANNELS);
    assign fire     = ctl.valid && ctl.advance && in_range;

    assign pending   = pend_reg[idx];
    assign stamp_cur = pending ? stage_cmd.now_ms : stamps_reg[idx];
    assign end_stamp = stamp_cur + stage_cmd.time_value;

    always_comb
    begin
        if (stamp_cur < end_stamp)
        begin
            reached = stage_cmd.now_ms >= end_stamp;
        end
        else
        begin
            reached = (stage_cmd.now_ms < stamp_cur) && (stage_cmd.now_ms > end_stamp);
        end
    end

    assign hit = in_range && (stage_cmd.op == OP_CHECK) && reached;

    always_comb
    begin
        stamp_we    = 1'b0;
        stamp_wdata = stage_cmd.now_ms;
        pend_we     = 1'b0;
        pend_wdata  = 1'b0;
        unique case (stage_cmd.op)
            OP_CHECK:
            begin
                stamp_we   = pending || reached;
                pend_we    = pending;
                pend_wdata = 1'b0;
            end
            OP_PENDING:
            begin
                pend_we    = 1'b1;
                pend_wdata = 1'b1;
            end
            OP_RESTART:
            begin
                stamp_we = 1'b1;
            end
            OP_SET:
            begin
                stamp_we    = 1'b1;
                stamp_wdata = stage_cmd.time_value;
            end
            default:
            begin
                stamp_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                stamps_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            if (pend_we)
            begin
                pend_reg[idx] <= pend_wdata;
            end
            if (stamp_we)
            begin
                stamps_reg[idx] <= stamp_wdata;
            end
        end
    end

endmodule

// ----- rtl/metb_result_stage.sv -----
// Result register of the timer bank, holding one result item until it is taken.
// Depends on metb_pkg and metb_res_if.
`timescale 1ns / 1ps

module metb_result_stage
    import metb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  metb_stage_ctl_t ctl,
    input  logic            hit,
    metb_res_if.source      res,
    output logic            advance
);

    logic valid_reg;
    logic valid_next;
    logic elapsed_reg;

    assign advance    = !valid_reg || res.ready;
    assign valid_next = ctl.advance ? ctl.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid && ctl.advance)
        begin
            elapsed_reg <= hit;
        end
    end

    assign res.valid   = valid_reg;
    assign res.elapsed = elapsed_reg;

endmodule

// ----- rtl/multichannel_elapsed_timer_bank_unit.sv -----
// A bank of CHANNELS elapsed-time timers, each with a 32-bit start stamp and a
// pending-restart flag, both cleared by reset. Every command item yields exactly one
// result item. The block takes one item per cycle while the result sink does not stall;
// an item passes an input register, is evaluated combinationally, updates its channel
// and is then captured in the result register, which holds while the sink stalls.
// Depends on metb_pkg, metb_if, the stage modules and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multichannel_elapsed_timer_bank_unit
    import metb_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
)
(
    input  logic       clk,
    input  logic       rst_n,
    metb_cmd_if.sink   cmd,
    metb_res_if.source res
);

    metb_stage_ctl_t ctl;
    metb_cmd_t       stage_cmd;
    logic            hit;
    logic            advance;

    metb_input_stage u_input (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .advance   (advance),
        .ctl       (ctl),
        .stage_cmd (stage_cmd)
    );

    metb_timer_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stage_cmd (stage_cmd),
        .hit       (hit)
    );

    metb_result_stage u_result (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .hit     (hit),
        .res     (res),
        .advance (advance)
    );

    `ASSERT_CLK(a_accept_fills_stage, cmd.valid && cmd.ready |=> ctl.valid, "Accepted item lost before evaluation")
    `ASSERT_CLK(a_stage_holds_on_stall, ctl.valid && !ctl.advance |=> ctl.valid, "Stalled item dropped")
    `ASSERT_CLK(a_hit_reaches_output, ctl.valid && ctl.advance && hit |=> res.valid && res.elapsed, "Elapsed result not delivered")
    `ASSERT_NEVER(a_hit_on_non_check, ctl.valid && hit && (stage_cmd.op != OP_CHECK), "Elapsed flagged on a non-check op")

endmodule

// ----- tb/tb_multichannel_elapsed_timer_bank_unit.sv -----
// Testbench for the elapsed timer bank: drives command items, predicts the elapsed flag
// per channel and checks every result item in order.
// Depends on metb_pkg, metb_if and multichannel_elapsed_timer_bank_unit.
`timescale 1ns / 1ps

module tb_multichannel_elapsed_timer_bank_unit;
    import metb_pkg::*;

    class timer_bank_scoreboard;
        logic [STAMP_W-1:0] stamps [DEF_CHANNELS];
        bit                 restart_flags [DEF_CHANNELS];
        bit                 elapsed_q [$];
        int                 errors;

        function new();
            foreach (stamps[i])
            begin
                stamps[i] = '0;
                restart_flags[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function bit predict_elapsed(metb_op_t op, logic [CH_W-1:0] ch,
                                     logic [STAMP_W-1:0] now, logic [STAMP_W-1:0] tv);
            logic [STAMP_W-1:0] start;
            logic [STAMP_W-1:0] deadline;
            bit                 hit;
            hit = 1'b0;
            if (ch < DEF_CHANNELS)
            begin
                case (op)
                    OP_CHECK:
                    begin
                        if (restart_flags[ch])
                        begin
                            restart_flags[ch] = 1'b0;
                            stamps[ch] = now;
                        end
                        start = stamps[ch];
                        deadline = start + tv;
                        if (start < deadline)
                            hit = (now >= deadline);
                        else
                            hit = (now < start) && (now > deadline);
                        if (hit)
                            stamps[ch] = now;
                    end
                    OP_PENDING: restart_flags[ch] = 1'b1;
                    OP_RESTART: stamps[ch] = now;
                    OP_SET:     stamps[ch] = tv;
                endcase
            end
            return hit;
        endfunction

        function void note_command(metb_op_t op, logic [CH_W-1:0] ch,
                                   logic [STAMP_W-1:0] now, logic [STAMP_W-1:0] tv);
            elapsed_q.push_back(predict_elapsed(op, ch, now, tv));
        endfunction

        function void check_elapsed(logic actual);
            bit expected;
            if (elapsed_q.size() == 0)
            begin
                $error("elapsed: result item with no expectation, actual %0b", actual);
                errors++;
                return;
            end
            expected = elapsed_q.pop_front();
            if (actual !== expected)
            begin
                $error("elapsed mismatch: expected %0b actual %0b", expected, actual);
                errors++;
            end
        endfunction

        function int outstanding();
            return elapsed_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    logic [STAMP_W-1:0] tick;
    timer_bank_scoreboard tally;

    metb_cmd_if cmd_if();
    metb_res_if res_if();

    multichannel_elapsed_timer_bank_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            tally.check_elapsed(res_if.elapsed);
    end

    task automatic send_cmd(input metb_op_t op, input logic [CH_W-1:0] ch,
                            input logic [STAMP_W-1:0] now, input logic [STAMP_W-1:0] tv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.channel    <= ch;
        cmd_if.now_ms     <= now;
        cmd_if.time_value <= tv;
        do
            @(posedge clk);
        while (!(cmd_if.valid && cmd_if.ready));
        tally.note_command(op, ch, now, tv);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        metb_op_t           op;
        logic [CH_W-1:0]    ch;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] tv;
        int                 roll;
        ch = $urandom_range(DEF_CHANNELS - 1);
        if ($urandom_range(99) < 25)
        begin
            op  = metb_op_t'($urandom_range(3));
            now = $urandom;
            tv  = $urandom;
        end
        else
        begin
            tick = tick + $urandom_range(40);
            now  = tick;
            roll = $urandom_range(99);
            if (roll < 55)
            begin
                op = OP_CHECK;
                tv = ($urandom_range(9) == 0) ? '0 : $urandom_range(1200);
            end
            else if (roll < 65)
            begin
                op = OP_PENDING;
                tv = $urandom;
            end
            else if (roll < 80)
            begin
                op = OP_RESTART;
                tv = $urandom;
            end
            else
            begin
                op = OP_SET;
                tv = tick - $urandom_range(300);
            end
        end
        send_cmd(op, ch, now, tv);
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (tally.outstanding() > 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input logic [STAMP_W-1:0] tick_start, input int count);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        tick = tick_start;
        repeat (count)
            send_random_item();
        drain_results();
    endtask

    initial
    begin
        tally = new();
        src_idle_pct = 11;
        snk_idle_pct = 82;
        tick = '0;
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.op = OP_CHECK;
        cmd_if.channel = '0;
        cmd_if.now_ms = '0;
        cmd_if.time_value = '0;
        res_if.ready = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_cmd(OP_CHECK,   4'd0,  32'd0,          32'd0);
        send_cmd(OP_CHECK,   4'd0,  32'd5,          32'd5);
        send_cmd(OP_CHECK,   4'd0,  32'd9,          32'd5);
        send_cmd(OP_CHECK,   4'd0,  32'd10,         32'd5);
        send_cmd(OP_PENDING, 4'd1,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_cmd(OP_CHECK,   4'd1,  32'd100,        32'd1);
        send_cmd(OP_CHECK,   4'd1,  32'd101,        32'd1);
        send_cmd(OP_SET,     4'd2,  32'd0,          32'hFFFF_FFF0);
        send_cmd(OP_CHECK,   4'd2,  32'hFFFF_FFF8,  32'h20);
        send_cmd(OP_CHECK,   4'd2,  32'h11,         32'h20);
        send_cmd(OP_RESTART, 4'd3,  32'hFFFF_FFFF,  32'd0);
        send_cmd(OP_CHECK,   4'd3,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_cmd(OP_CHECK,   4'd3,  32'd0,          32'd0);
        send_cmd(OP_SET,     4'd15, 32'h5555_AAAA,  32'd0);
        send_cmd(OP_CHECK,   4'd15, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_cmd(OP_PENDING, 4'd4,  32'd0,          32'd0);
        send_cmd(OP_RESTART, 4'd4,  32'd50,         32'd0);
        send_cmd(OP_CHECK,   4'd4,  32'd70,         32'd10);
        send_cmd(OP_PENDING, 4'd5,  32'd0,          32'd0);
        send_cmd(OP_SET,     4'd5,  32'd0,          32'd7);
        send_cmd(OP_CHECK,   4'd5,  32'd1000,       32'd0);
        drain_results();

        run_phase(11, 82, $urandom, 560);
        run_phase(82, 11, 32'hFFFF_F000 + $urandom_range(2000), 560);
        run_phase(0, 0, $urandom, 560);

        repeat (8) @(posedge clk);
        if (tally.errors == 0)
            $display("tb_multichannel_elapsed_timer_bank_unit: clean");
        else
            $display("tb_multichannel_elapsed_timer_bank_unit: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_multichannel_elapsed_timer_bank_unit: errors");
        $finish;
    end

endmodule
